@@ hw/rtl/msqd_pkg.sv @@
// shared types, constants and register codes of the multi-server queue dispatch unit
package msqd_pkg;

   // default sizes of the server array and of each server queue
   localparam int DEF_MAX_SERVERS = 32;
   localparam int DEF_MAX_DEPTH   = 16;

   // field widths
   localparam int TIME_W      = 16;
   localparam int SVC_W       = 10;
   localparam int JOB_W       = 16;
   localparam int SRV_OUT_W   = 5;
   localparam int NW_W        = 6;
   localparam int CAP_W       = 5;
   localparam int MIN_W       = 11;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 11;
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 56;

   // register reset values, minutes of the day
   localparam int RESET_OPEN  = 480;
   localparam int RESET_CLOSE = 17 * 60;

   typedef logic [TIME_W-1:0] time_type;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NUM_WINDOWS = 2'd0,
      CSR_QUEUE_CAP   = 2'd1,
      CSR_OPEN_TIME   = 2'd2,
      CSR_CLOSE_TIME  = 2'd3
   } csr_index_type;

endpackage

@@ hw/rtl/msqd_slot_ram.sv @@
// queued finish time memory, one write and one registered read per cycle
module msqd_slot_ram
   import msqd_pkg::*;
#(
   parameter int DEPTH = DEF_MAX_SERVERS * DEF_MAX_DEPTH,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  time_type          wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output time_type          rd_data
);

   time_type mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

@@ hw/rtl/msqd_scan.sv @@
// earliest head finish search, one server compared per cycle
module msqd_scan
   import msqd_pkg::*;
#(
   parameter int MAX_SERVERS = DEF_MAX_SERVERS,
   localparam int SRV_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1,
   localparam int CNT_W = SRV_W + 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [CNT_W-1:0] srv_count,
   input  time_type         head_time,
   output logic [SRV_W-1:0] rd_idx,
   output logic             done,
   output logic [SRV_W-1:0] best_idx
);

   logic             busy_ff;
   logic             done_ff;
   logic [SRV_W-1:0] idx_ff;
   logic [SRV_W-1:0] best_idx_ff;
   time_type         best_val_ff;
   logic             take;
   logic             last;

   // strict compare keeps the lowest index on ties
   assign take = (idx_ff == '0) || (head_time < best_val_ff);
   assign last = (CNT_W'(idx_ff) + CNT_W'(1)) >= srv_count;

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         done_ff <= busy_ff && !start && last;
         if (start) begin
            busy_ff <= 1'b1;
            idx_ff  <= '0;
         end else if (busy_ff) begin
            if (last) begin
               busy_ff <= 1'b0;
            end else begin
               idx_ff <= idx_ff + SRV_W'(1);
            end
         end
      end
   end

   // running minimum
   always_ff @(posedge clock) begin
      if (busy_ff && take && !start) begin
         best_idx_ff <= idx_ff;
         best_val_ff <= head_time;
      end
   end

   assign rd_idx   = idx_ff;
   assign done     = done_ff;
   assign best_idx = best_idx_ff;

endmodule

@@ hw/rtl/multi_server_bounded_queue_dispatch_unit.sv @@
// Multi-server bounded-queue dispatcher: each request transfer carries one job (service
// time in minutes, new_batch flag in tuser) and yields one response with the job number,
// chosen server, start and finish minute and a late flag. The first num_windows * queue_cap
// jobs of a batch fill the server queues round robin. After that a job goes to the server
// whose head job finishes first; that search compares one server head time per cycle.
// Either kind of job waits longer only while the previous response still sits in the
// output register. The request side is ready only between jobs; a finished response
// waits in an output register while the next job is already taken. The queued finish
// memory is not cleared and needs no start-up pass.
module multi_server_bounded_queue_dispatch_unit
   import msqd_pkg::*;
#(
   parameter int MAX_SERVERS = DEF_MAX_SERVERS,
   parameter int MAX_DEPTH   = DEF_MAX_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   // job requests
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // [9:0] service_time
   input  logic                   req_tuser,   // [0] new_batch
   // dispatch responses
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // [15:0] job_number, [20:16] server_index,
                                               // [36:21] start_minute, [52:37] finish_minute
   output logic                   rsp_tuser,   // [0] too_late
   // configuration writes
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int SRV_W     = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
   localparam int CNT_W     = SRV_W + 1;
   localparam int DEP_W     = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
   localparam int FR_W      = $clog2(MAX_DEPTH + 2);
   localparam int RAM_DEPTH = MAX_SERVERS * MAX_DEPTH;
   localparam int ADDR_W    = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_PREP   = 9'b000000010,
      ST_FILL   = 9'b000000100,
      ST_FILLH  = 9'b000001000,
      ST_SCAN   = 9'b000010000,
      ST_STEADY = 9'b000100000,
      ST_RDADDR = 9'b001000000,
      ST_RDDATA = 9'b010000000,
      ST_DONE   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   // configuration registers
   logic [NW_W-1:0]  num_windows_ff;
   logic [CAP_W-1:0] queue_cap_ff;
   logic [MIN_W-1:0] open_time_ff;
   logic [MIN_W-1:0] close_time_ff;

   // per-server state
   time_type         head_finish_ff [MAX_SERVERS];
   time_type         tail_finish_ff [MAX_SERVERS];
   logic [DEP_W-1:0] head_slot_ff   [MAX_SERVERS];
   logic [SRV_W-1:0] fill_server_ff;
   logic [FR_W-1:0]  fill_row_ff;
   logic [JOB_W-1:0] job_count_ff;

   // current job
   logic [SVC_W-1:0] minutes_ff;
   logic [SRV_W-1:0] srv_ff;
   time_type         start_ff;
   time_type         finish_ff;

   // response register
   logic                   rsp_tvalid_ff;
   logic [RSP_TDATA_W-1:0] rsp_tdata_ff;
   logic                   rsp_tuser_ff;

   logic [CNT_W-1:0]  nsrv_eff;
   logic [FR_W-1:0]   cap_eff;
   logic [SRV_W-1:0]  head_rd_idx;
   time_type          head_rd;
   time_type          tail_rd;
   logic [DEP_W-1:0]  slot_rd;
   time_type          add_a;
   logic [TIME_W:0]   add_sum;
   time_type          add_sat;
   logic              fill_wrap;
   logic [FR_W-1:0]   fr_eff;
   logic              fill_phase;
   logic [CNT_W-1:0]  fs_next;
   logic              fs_wrap;
   logic [DEP_W-1:0]  hs;
   logic [FR_W-1:0]   nh_wide;
   logic [DEP_W-1:0]  nh;
   logic [ADDR_W-1:0] srv_base;
   logic [FR_W-1:0]   row_sel;
   logic              out_free;
   logic              scan_start;
   logic [SRV_W-1:0]  scan_idx;
   logic              scan_done;
   logic [SRV_W-1:0]  scan_best;
   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic              ram_rd_en;
   logic [ADDR_W-1:0] ram_rd_addr;
   time_type          ram_rd_data;

   // servers and queue depth in use, clamped into range
   always_comb begin
      if (num_windows_ff == '0) begin
         nsrv_eff = CNT_W'(1);
      end else if (int'(num_windows_ff) > MAX_SERVERS) begin
         nsrv_eff = CNT_W'(MAX_SERVERS);
      end else begin
         nsrv_eff = CNT_W'(num_windows_ff);
      end
      if (queue_cap_ff == '0) begin
         cap_eff = FR_W'(1);
      end else if (int'(queue_cap_ff) > MAX_DEPTH) begin
         cap_eff = FR_W'(MAX_DEPTH);
      end else begin
         cap_eff = FR_W'(queue_cap_ff);
      end
   end

   // per-server read ports
   assign head_rd_idx = (state_ff == ST_SCAN) ? scan_idx : srv_ff;
   assign head_rd     = head_finish_ff[head_rd_idx];
   assign tail_rd     = tail_finish_ff[srv_ff];
   assign slot_rd     = head_slot_ff[srv_ff];

   // shared saturating adder
   assign add_a   = (state_ff == ST_FILLH) ? head_rd : tail_rd;
   assign add_sum = {1'b0, add_a} + (TIME_W + 1)'(minutes_ff);
   assign add_sat = add_sum[TIME_W] ? '1 : add_sum[TIME_W-1:0];

   // fill position, moved to the next row when the server count shrank
   assign fill_wrap  = CNT_W'(fill_server_ff) >= nsrv_eff;
   assign fr_eff     = fill_wrap ? fill_row_ff + FR_W'(1) : fill_row_ff;
   assign fill_phase = fr_eff < cap_eff;
   assign fs_next    = CNT_W'(fill_server_ff) + CNT_W'(1);
   assign fs_wrap    = fs_next >= nsrv_eff;

   // head slot of the chosen server and its successor
   assign hs      = (FR_W'(slot_rd) >= cap_eff) ? '0 : slot_rd;
   assign nh_wide = FR_W'(hs) + FR_W'(1);
   assign nh      = (nh_wide >= cap_eff) ? '0 : DEP_W'(nh_wide);

   // queue memory addressing
   assign srv_base    = ADDR_W'(srv_ff * MAX_DEPTH);
   assign row_sel     = (state_ff == ST_FILL) ? fill_row_ff : FR_W'(hs);
   assign ram_wr_en   = (state_ff == ST_FILL) || (state_ff == ST_STEADY);
   assign ram_wr_addr = srv_base + ADDR_W'(row_sel);
   assign ram_rd_en   = (state_ff == ST_RDADDR);
   assign ram_rd_addr = srv_base + ADDR_W'(slot_rd);

   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign scan_start = (state_ff == ST_PREP) && !fill_phase;

   msqd_scan #(
      .MAX_SERVERS(MAX_SERVERS)
   ) u_scan (
      .clock    (clock),
      .reset    (reset),
      .start    (scan_start),
      .srv_count(nsrv_eff),
      .head_time(head_rd),
      .rd_idx   (scan_idx),
      .done     (scan_done),
      .best_idx (scan_best)
   );

   msqd_slot_ram #(
      .DEPTH(RAM_DEPTH)
   ) u_slot_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(add_sat),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_PREP;
         end
         ST_PREP: begin
            state_in = fill_phase ? ST_FILL : ST_SCAN;
         end
         ST_FILL: begin
            state_in = (fill_row_ff == '0) ? ST_FILLH : ST_DONE;
         end
         ST_FILLH: begin
            state_in = ST_DONE;
         end
         ST_SCAN: begin
            if (scan_done) state_in = ST_STEADY;
         end
         ST_STEADY: begin
            state_in = ST_RDADDR;
         end
         ST_RDADDR: begin
            state_in = ST_RDDATA;
         end
         ST_RDDATA: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // configuration, per-server state and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         num_windows_ff <= NW_W'(1);
         queue_cap_ff   <= CAP_W'(1);
         open_time_ff   <= MIN_W'(RESET_OPEN);
         close_time_ff  <= MIN_W'(RESET_CLOSE);
         for (int i = 0; i < MAX_SERVERS; i++) begin
            head_finish_ff[i] <= TIME_W'(RESET_OPEN);
            tail_finish_ff[i] <= TIME_W'(RESET_OPEN);
            head_slot_ff[i]   <= '0;
         end
         fill_server_ff <= '0;
         fill_row_ff    <= '0;
         job_count_ff   <= '0;
         rsp_tvalid_ff  <= 1'b0;
      end else begin
         // register writes
         if (csr_we) begin
            unique case (csr_index_type'(csr_index))
               CSR_NUM_WINDOWS: num_windows_ff <= csr_wdata[NW_W-1:0];
               CSR_QUEUE_CAP:   queue_cap_ff   <= csr_wdata[CAP_W-1:0];
               CSR_OPEN_TIME:   open_time_ff   <= csr_wdata[MIN_W-1:0];
               CSR_CLOSE_TIME:  close_time_ff  <= csr_wdata[MIN_W-1:0];
               default: ;
            endcase
         end

         // response taken downstream, unless the next one is loaded now
         if (rsp_tvalid_ff && rsp_tready && (state_ff != ST_DONE)) begin
            rsp_tvalid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               // job accepted, new batch clears all queues first
               if (req_tvalid) begin
                  minutes_ff <= req_tdata[SVC_W-1:0];
                  if (req_tuser) begin
                     for (int i = 0; i < MAX_SERVERS; i++) begin
                        head_finish_ff[i] <= TIME_W'(open_time_ff);
                        tail_finish_ff[i] <= TIME_W'(open_time_ff);
                        head_slot_ff[i]   <= '0;
                     end
                     fill_server_ff <= '0;
                     fill_row_ff    <= '0;
                     job_count_ff   <= '0;
                  end
               end
            end
            ST_PREP: begin
               if (fill_wrap) begin
                  fill_server_ff <= '0;
                  fill_row_ff    <= fr_eff;
               end
               if (fill_phase) begin
                  srv_ff <= fill_wrap ? '0 : fill_server_ff;
               end
            end
            ST_FILL: begin
               // append at the tail, then advance round robin
               tail_finish_ff[srv_ff] <= add_sat;
               start_ff               <= tail_rd;
               finish_ff              <= add_sat;
               if (fs_wrap) begin
                  fill_server_ff <= '0;
                  fill_row_ff    <= fill_row_ff + FR_W'(1);
               end else begin
                  fill_server_ff <= SRV_W'(fs_next);
               end
            end
            ST_FILLH: begin
               head_finish_ff[srv_ff] <= add_sat;
            end
            ST_SCAN: begin
               if (scan_done) srv_ff <= scan_best;
            end
            ST_STEADY: begin
               // retired head slot becomes the new tail
               tail_finish_ff[srv_ff] <= add_sat;
               start_ff               <= tail_rd;
               finish_ff              <= add_sat;
               head_slot_ff[srv_ff]   <= nh;
            end
            ST_RDDATA: begin
               head_finish_ff[srv_ff] <= ram_rd_data;
            end
            ST_DONE: begin
               if (out_free) begin
                  rsp_tvalid_ff <= 1'b1;
                  rsp_tdata_ff  <= {3'b000, finish_ff, start_ff, SRV_OUT_W'(srv_ff),
                                    job_count_ff};
                  rsp_tuser_ff  <= start_ff >= TIME_W'(close_time_ff);
                  if (job_count_ff != '1) begin
                     job_count_ff <= job_count_ff + JOB_W'(1);
                  end
               end
            end
            default: ;
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

@@ sim/multi_server_bounded_queue_dispatch_unit_test.sv @@
// self-checking testbench for the multi-server bounded-queue dispatch unit
module multi_server_bounded_queue_dispatch_unit_test
   import msqd_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int JOB_SAT        = 65535;

   typedef struct packed {
      logic [JOB_W-1:0]     job;
      logic [SRV_OUT_W-1:0] server;
      time_type             start;
      time_type             finish;
      logic                 late;
   } dispatch_type;

   typedef enum {ROW_JOB, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type         kind;
      csr_index_type        reg_sel;
      logic [CSR_DATA_W-1:0] reg_value;
      logic [SVC_W-1:0]     service;
      logic                 batch;
      bit                   typed;
      dispatch_type         want;
   } stim_row_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   req_tuser  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;
   logic                   csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   multi_server_bounded_queue_dispatch_unit DUT (.*);

   always #6 clock = ~clock;

   // predictor copy of the registers
   logic [NW_W-1:0]  cfg_windows;
   logic [CAP_W-1:0] cfg_depth;
   logic [MIN_W-1:0] cfg_open;
   logic [MIN_W-1:0] cfg_close;

   // predictor copy of the server queues
   time_type        head_done [DEF_MAX_SERVERS];
   time_type        tail_done [DEF_MAX_SERVERS];
   time_type        slot_done [DEF_MAX_SERVERS*DEF_MAX_DEPTH];
   logic [3:0]      head_ptr  [DEF_MAX_SERVERS];
   int              fill_srv;
   int              fill_rw;
   logic [JOB_W-1:0] batch_jobs;

   dispatch_type pending_dispatch[$];
   int        mismatches = 0;
   int        sender_gap_pct = 0;
   int        receiver_stall_pct = 0;
   int        quiet_cycles = 0;

   function automatic time_type add_minutes(time_type a, int b);
      int s;
      s = int'(a) + b;
      return (s > JOB_SAT) ? time_type'(JOB_SAT) : time_type'(s);
   endfunction

   function automatic void clear_queues();
      for (int i = 0; i < DEF_MAX_SERVERS; i++) begin
         head_done[i] = time_type'(cfg_open);
         tail_done[i] = time_type'(cfg_open);
         head_ptr[i]  = '0;
      end
      fill_srv   = 0;
      fill_rw    = 0;
      batch_jobs = '0;
   endfunction

   function automatic int servers_in_use();
      if (cfg_windows < 1) return 1;
      if (cfg_windows > DEF_MAX_SERVERS) return DEF_MAX_SERVERS;
      return int'(cfg_windows);
   endfunction

   function automatic int depth_in_use();
      if (cfg_depth < 1) return 1;
      if (cfg_depth > DEF_MAX_DEPTH) return DEF_MAX_DEPTH;
      return int'(cfg_depth);
   endfunction

   // works out the dispatch of one job and advances the queue state
   function automatic dispatch_type dispatch_job(logic [SVC_W-1:0] service, logic batch);
      dispatch_type d;
      int        nsrv;
      int        cap;
      int        w;
      int        hs;
      int        nh;
      time_type  start;
      time_type  finish;
      if (batch) clear_queues();
      nsrv = servers_in_use();
      cap  = depth_in_use();
      if (fill_srv >= nsrv) begin
         fill_srv = 0;
         fill_rw++;
      end
      if (fill_rw < cap) begin
         // round-robin fill
         w      = fill_srv;
         start  = tail_done[w];
         finish = add_minutes(start, int'(service));
         tail_done[w] = finish;
         if (fill_rw == 0) head_done[w] = add_minutes(head_done[w], int'(service));
         slot_done[w*DEF_MAX_DEPTH + fill_rw] = finish;
         fill_srv++;
         if (fill_srv >= nsrv) begin
            fill_srv = 0;
            fill_rw++;
         end
      end else begin
         // earliest head wins, lowest index on ties
         w = 0;
         for (int j = 1; j < nsrv; j++)
            if (head_done[j] < head_done[w]) w = j;
         hs = int'(head_ptr[w]);
         if (hs >= cap) hs = 0;
         start  = tail_done[w];
         finish = add_minutes(start, int'(service));
         tail_done[w] = finish;
         slot_done[w*DEF_MAX_DEPTH + hs] = finish;
         nh = hs + 1;
         if (nh >= cap) nh = 0;
         head_ptr[w]  = nh[3:0];
         head_done[w] = slot_done[w*DEF_MAX_DEPTH + nh];
      end
      d.job    = batch_jobs;
      d.server = w[SRV_OUT_W-1:0];
      d.start  = start;
      d.finish = finish;
      d.late   = (start >= time_type'(cfg_close));
      if (batch_jobs < JOB_SAT) batch_jobs++;
      return d;
   endfunction

   function automatic stim_row_type job_row(logic [SVC_W-1:0] service, logic batch);
      stim_row_type r;
      r.kind    = ROW_JOB;
      r.reg_sel = CSR_NUM_WINDOWS;
      r.reg_value = '0;
      r.service = service;
      r.batch   = batch;
      r.typed   = 1'b0;
      r.want    = '0;
      return r;
   endfunction

   function automatic stim_row_type typed_row(logic [SVC_W-1:0] service, logic batch,
                                              int job, int server, int start, int finish,
                                              bit late);
      stim_row_type r;
      r = job_row(service, batch);
      r.typed = 1'b1;
      r.want  = '{job[JOB_W-1:0], server[SRV_OUT_W-1:0], start[TIME_W-1:0],
                  finish[TIME_W-1:0], late};
      return r;
   endfunction

   function automatic stim_row_type csr_row(csr_index_type sel, int value);
      stim_row_type r;
      r = job_row('0, 1'b0);
      r.kind      = ROW_CSR;
      r.reg_sel   = sel;
      r.reg_value = value[CSR_DATA_W-1:0];
      return r;
   endfunction

   function automatic logic [SVC_W-1:0] pick_service();
      case ($urandom_range(0, 15))
         0: return '0;
         1: return '1;
         2: return 10'd1;
         default: return SVC_W'($urandom_range(0, 1023));
      endcase
   endfunction

   task automatic report_mismatch(string msg);
      mismatches++;
      $display("mismatch at %0t: %s", $realtime, msg);
   endtask

   // one register write, then the enable dropped low again
   task automatic write_reg(csr_index_type sel, logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= sel;
      csr_wdata <= value;
      @(posedge clock);
      case (sel)
         CSR_NUM_WINDOWS: cfg_windows = value[NW_W-1:0];
         CSR_QUEUE_CAP:   cfg_depth   = value[CAP_W-1:0];
         CSR_OPEN_TIME:   cfg_open    = value[MIN_W-1:0];
         CSR_CLOSE_TIME:  cfg_close   = value[MIN_W-1:0];
         default: ;
      endcase
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // present one job, wait for its transfer, queue the expected dispatch
   task automatic send_job(logic [SVC_W-1:0] service, logic batch, bit typed,
                           dispatch_type want);
      dispatch_type d;
      while ($urandom_range(0, 99) < sender_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_TDATA_W'(service);
      req_tuser  <= batch;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      d = dispatch_job(service, batch);
      pending_dispatch.push_back(typed ? want : d);
   endtask

   // let every outstanding dispatch come back before touching registers
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_dispatch.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // response check and receiver stalls
   always @(posedge clock) begin
      dispatch_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_dispatch.size() == 0) begin
            report_mismatch($sformatf("unexpected transfer job %0d", rsp_tdata[15:0]));
         end else begin
            want = pending_dispatch.pop_front();
            if (rsp_tdata[15:0] !== want.job)
               report_mismatch($sformatf("job_number got %0d expected %0d",
                                         rsp_tdata[15:0], want.job));
            if (rsp_tdata[20:16] !== want.server)
               report_mismatch($sformatf("job %0d server_index got %0d expected %0d",
                                         want.job, rsp_tdata[20:16], want.server));
            if (rsp_tdata[36:21] !== want.start)
               report_mismatch($sformatf("job %0d start_minute got %0d expected %0d",
                                         want.job, rsp_tdata[36:21], want.start));
            if (rsp_tdata[52:37] !== want.finish)
               report_mismatch($sformatf("job %0d finish_minute got %0d expected %0d",
                                         want.job, rsp_tdata[52:37], want.finish));
            if (rsp_tuser !== want.late)
               report_mismatch($sformatf("job %0d too_late got %0b expected %0b",
                                         want.job, rsp_tuser, want.late));
         end
      end
      rsp_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      stim_row_type directed_rows[$];
      int        batch_left;
      logic      batch;
      int        pick;
      cfg_windows = 6'd1;
      cfg_depth   = 5'd1;
      cfg_open    = MIN_W'(RESET_OPEN);
      cfg_close   = MIN_W'(RESET_CLOSE);
      foreach (slot_done[i]) slot_done[i] = '0;
      clear_queues();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed table: reset registers, zero and full service times, register extremes
      directed_rows.push_back(typed_row(10'd5,    1'b0, 0, 0, 480,  485,  1'b0));
      directed_rows.push_back(typed_row(10'd10,   1'b0, 1, 0, 485,  495,  1'b0));
      directed_rows.push_back(typed_row(10'd1023, 1'b1, 0, 0, 480,  1503, 1'b0));
      directed_rows.push_back(typed_row(10'd0,    1'b0, 1, 0, 1503, 1503, 1'b1));
      directed_rows.push_back(csr_row(CSR_CLOSE_TIME, 0));
      directed_rows.push_back(csr_row(CSR_OPEN_TIME, 1439));
      directed_rows.push_back(typed_row(10'd1023, 1'b1, 0, 0, 1439, 2462, 1'b1));
      // zero server count and zero depth act as one
      directed_rows.push_back(csr_row(CSR_NUM_WINDOWS, 0));
      directed_rows.push_back(csr_row(CSR_QUEUE_CAP, 0));
      directed_rows.push_back(typed_row(10'd1,    1'b1, 0, 0, 1439, 1440, 1'b1));
      directed_rows.push_back(job_row(10'd7, 1'b0));
      directed_rows.push_back(job_row(10'd0, 1'b0));
      // oversized counts clamp to the array size
      directed_rows.push_back(csr_row(CSR_NUM_WINDOWS, 63));
      directed_rows.push_back(csr_row(CSR_QUEUE_CAP, 31));
      directed_rows.push_back(csr_row(CSR_OPEN_TIME, 0));
      directed_rows.push_back(csr_row(CSR_CLOSE_TIME, 1439));
      directed_rows.push_back(typed_row(10'd1023, 1'b1, 0, 0, 0, 1023, 1'b0));
      directed_rows.push_back(job_row(10'd512, 1'b0));
      directed_rows.push_back(job_row(10'd1, 1'b0));
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            drain();
            write_reg(directed_rows[i].reg_sel, directed_rows[i].reg_value);
         end else begin
            send_job(directed_rows[i].service, directed_rows[i].batch,
                     directed_rows[i].typed, directed_rows[i].want);
         end
      end

      // finish filling every server queue to full depth, then some dispatches
      repeat (540) send_job(pick_service(), 1'b0, 1'b0, '0);

      // random phases: new register settings, batches of random jobs, idling modes
      batch_left = 0;
      for (int phase = 0; phase < 8; phase++) begin
         drain();
         case (phase % 4)
            0: begin sender_gap_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_gap_pct = 50; receiver_stall_pct = 0;  end
            2: begin sender_gap_pct = 0;  receiver_stall_pct = 50; end
            default: begin sender_gap_pct = 27; receiver_stall_pct = 27; end
         endcase
         pick = $urandom_range(0, 9);
         write_reg(CSR_NUM_WINDOWS, CSR_DATA_W'((pick == 0) ? 0 : (pick == 1) ? 1 :
                   (pick == 2) ? 32 : (pick == 3) ? 63 :
                   (pick == 4) ? $urandom_range(1, 32) :
                   (pick == 5) ? $urandom_range(33, 63) : $urandom_range(1, 6)));
         pick = $urandom_range(0, 9);
         write_reg(CSR_QUEUE_CAP, CSR_DATA_W'((pick == 0) ? 0 : (pick == 1) ? 1 :
                   (pick == 2) ? 16 : (pick == 3) ? 31 :
                   (pick == 4) ? $urandom_range(17, 31) : $urandom_range(1, 4)));
         pick = $urandom_range(0, 5);
         write_reg(CSR_OPEN_TIME, CSR_DATA_W'((pick == 0) ? 0 : (pick == 1) ? 1439 :
                   (pick == 2) ? 2047 : $urandom_range(0, 2047)));
         pick = $urandom_range(0, 5);
         write_reg(CSR_CLOSE_TIME, CSR_DATA_W'((pick == 0) ? 0 : (pick == 1) ? 1439 :
                   (pick == 2) ? 2047 : $urandom_range(0, 2047)));
         for (int k = 0; k < 40; k++) begin
            // a batch runs through its fill and well into dispatch; rare early restarts
            if (k == 0) batch = ($urandom_range(0, 1) == 1);
            else if (batch_left == 0) batch = 1'b1;
            else batch = ($urandom_range(0, 31) == 0);
            if (batch) batch_left = servers_in_use() * depth_in_use() + $urandom_range(0, 30);
            else if (batch_left > 0) batch_left--;
            send_job(pick_service(), batch, 1'b0, '0);
         end
      end

      drain();
      repeat (64) @(posedge clock);
      if (mismatches == 0 && pending_dispatch.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
